// File: hw/rtl/assert_macros.svh
// Assertion helpers for the timer unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/mcrt_pkg.sv
package mcrt_pkg;

    // Command codes carried on func; 5..7 are no-ops.
    typedef enum logic [2:0] {
        FUNC_START     = 3'd0,
        FUNC_RESUME    = 3'd1,
        FUNC_SET_DELAY = 3'd2,
        FUNC_STOP      = 3'd3,
        FUNC_TICK      = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD,
        ST_OUT
    } state_t;

    // Command seen by the channel update logic.
    typedef struct packed {
        func_t func;
        logic  hit;     // addressed channel is the one being processed
    } cmd_t;

    // Event reported by the channel update logic.
    typedef struct packed {
        logic fire;
        logic fin;
    } evt_t;

    localparam int DELAY_W = 31;
    localparam int COUNT_W = 16;
    localparam int CHAN_W  = 4;
    localparam logic [DELAY_W-1:0] WAIT_MAX = 31'h7FFF_FFFF;

endpackage

// File: hw/rtl/mcrt_ram.sv
module mcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mcrt_chan_alu.sv
// Next state of one channel entry for the current command or tick.
module mcrt_chan_alu #(
    parameter int TIME_BITS = 32
) (
    input  mcrt_pkg::cmd_t                   cmd,
    input  logic [TIME_BITS-1:0]             now,
    input  logic [mcrt_pkg::DELAY_W-1:0]     dly,
    input  logic [mcrt_pkg::COUNT_W-1:0]     cnt,
    input  logic [TIME_BITS-1:0]             deadline_in,
    input  logic [mcrt_pkg::DELAY_W-1:0]     period_in,
    input  logic [mcrt_pkg::COUNT_W-1:0]     remaining_in,
    input  logic                             running_in,
    input  logic                             looping_in,
    output logic [TIME_BITS-1:0]             deadline_out,
    output logic [mcrt_pkg::DELAY_W-1:0]     period_out,
    output logic [mcrt_pkg::COUNT_W-1:0]     remaining_out,
    output logic                             running_out,
    output logic                             looping_out,
    output mcrt_pkg::evt_t                   evt,
    output logic [TIME_BITS-1:0]             wait_post
);

    localparam int EXT_W = (TIME_BITS > mcrt_pkg::DELAY_W) ? TIME_BITS : mcrt_pkg::DELAY_W;
    localparam logic [EXT_W-1:0] HALF = EXT_W'(1) << (TIME_BITS - 1);

    logic [TIME_BITS-1:0]         wait_old;
    logic                         due;
    logic [mcrt_pkg::DELAY_W-1:0] arm_period;
    logic [EXT_W-1:0]             p_ext;
    logic [TIME_BITS-1:0]         p_clamp;
    logic                         arm;

    // wrapped distance; half range or more means already past
    assign wait_old = deadline_in - now;
    assign due      = (wait_old == '0) || wait_old[TIME_BITS-1];

    assign arm_period = (cmd.func == mcrt_pkg::FUNC_START || cmd.func == mcrt_pkg::FUNC_SET_DELAY)
                        ? dly : period_in;
    assign p_ext   = EXT_W'(arm_period);
    assign p_clamp = (p_ext >= HALF) ? TIME_BITS'(HALF - EXT_W'(1)) : TIME_BITS'(p_ext);

    always_comb
    begin
        period_out    = period_in;
        remaining_out = remaining_in;
        running_out   = running_in;
        looping_out   = looping_in;
        evt           = '0;
        arm           = 1'b0;
        unique case (cmd.func)
            mcrt_pkg::FUNC_TICK:
            begin
                if (running_in && due)
                begin
                    evt.fire = 1'b1;
                    arm      = 1'b1;
                    if (!looping_in)
                    begin
                        if (remaining_in <= mcrt_pkg::COUNT_W'(1))
                        begin
                            remaining_out = '0;
                            running_out   = 1'b0;
                            evt.fin       = 1'b1;
                            arm           = 1'b0;
                        end
                        else
                        begin
                            remaining_out = remaining_in - mcrt_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            mcrt_pkg::FUNC_START:
            begin
                if (cmd.hit)
                begin
                    period_out    = dly;
                    remaining_out = cnt;
                    looping_out   = (cnt == '0);
                    running_out   = 1'b1;
                    arm           = 1'b1;
                end
            end
            mcrt_pkg::FUNC_RESUME:
            begin
                if (cmd.hit)
                begin
                    running_out = 1'b1;
                    arm         = 1'b1;
                end
            end
            mcrt_pkg::FUNC_SET_DELAY:
            begin
                if (cmd.hit)
                begin
                    period_out = dly;
                    arm        = running_in;
                end
            end
            mcrt_pkg::FUNC_STOP:
            begin
                if (cmd.hit)
                begin
                    running_out = 1'b0;
                end
            end
            default:
            begin
                arm = 1'b0;
            end
        endcase
    end

    // After arming, the distance to the deadline is the clamped period itself.
    assign deadline_out = arm ? (now + p_clamp) : deadline_in;
    assign wait_post    = arm ? p_clamp : (due ? '0 : wait_old);

endmodule

// File: hw/rtl/multi_channel_repeat_timer_unit.sv
// Channel  Handshake             Payload
// ------   --------------------  ----------------------------------------------
// in       in_valid / in_ready   func, channel, delay_ms, repeat_count
// out      out_valid / out_ready fired, fired_channel, finished, last,
//                                any_running, next_wait_ms
//
// One transaction at a time. After an input transaction the unit sweeps the
// channel table, one entry per cycle (a rate set by the single read/write
// port pair of the table RAM), then sends its R results, each through the
// fetch, load and output states, waiting in the output state for out_ready.
// Reset is immediate: per-entry valid flops stand in for the table contents,
// no clearing pass. A stalled output simply holds the unit in its send state.
`include "assert_macros.svh"

module multi_channel_repeat_timer_unit #(
    parameter int NUM_CHANNELS = 16,
    parameter int TIME_BITS    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        func,
    input  logic [mcrt_pkg::CHAN_W-1:0]       channel,
    input  logic [mcrt_pkg::DELAY_W-1:0]      delay_ms,
    input  logic [mcrt_pkg::COUNT_W-1:0]      repeat_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              fired,
    output logic [mcrt_pkg::CHAN_W-1:0]       fired_channel,
    output logic                              finished,
    output logic                              last,
    output logic                              any_running,
    output logic [mcrt_pkg::DELAY_W-1:0]      next_wait_ms
);

    localparam int CH_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_BITS = $clog2(NUM_CHANNELS + 1);
    localparam int CMP_W    = (CH_BITS > mcrt_pkg::CHAN_W) ? CH_BITS : mcrt_pkg::CHAN_W;
    localparam int EXT_W    = (TIME_BITS > mcrt_pkg::DELAY_W) ? TIME_BITS : mcrt_pkg::DELAY_W;
    // table entry: {deadline, period, remaining, running, looping}
    localparam int ENT_W    = TIME_BITS + mcrt_pkg::DELAY_W + mcrt_pkg::COUNT_W + 2;
    localparam int RQ_W     = CH_BITS + 1;
    localparam logic [ENT_W-1:0] ENT_RESET = ENT_W'(1);   // only looping set

    mcrt_pkg::state_t state_reg, state_next;

    // latched command
    mcrt_pkg::func_t              func_reg;
    logic [mcrt_pkg::CHAN_W-1:0]  channel_reg;
    logic [mcrt_pkg::DELAY_W-1:0] delay_reg;
    logic [mcrt_pkg::COUNT_W-1:0] count_reg;

    logic [TIME_BITS-1:0]   now_reg;
    logic [CH_BITS-1:0]     proc_idx_reg;
    logic [CNT_BITS-1:0]    fire_cnt_reg;
    logic [CNT_BITS-1:0]    rd_idx_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;
    logic                   any_reg;
    logic [TIME_BITS-1:0]   best_reg;

    logic                         out_valid_reg;
    logic                         fired_reg;
    logic [mcrt_pkg::CHAN_W-1:0]  fired_channel_reg;
    logic                         finished_reg;
    logic                         last_reg;
    logic [mcrt_pkg::DELAY_W-1:0] wait_out_reg;

    // FSM decoded controls
    logic accept_in;
    logic scan_active;
    logic load_active;
    logic scan_done;
    logic send_done;

    // table RAM
    logic [ENT_W-1:0]   ent_rdata;
    logic [ENT_W-1:0]   ent_cur;
    logic [ENT_W-1:0]   ent_wdata;
    logic [CH_BITS-1:0] ent_raddr;

    // result queue RAM
    logic               rq_we;
    logic [RQ_W-1:0]    rq_wdata;
    logic [RQ_W-1:0]    rq_rdata;

    // channel update
    mcrt_pkg::cmd_t               cmd;
    mcrt_pkg::evt_t               evt;
    logic [TIME_BITS-1:0]         dl_in, dl_out;
    logic [mcrt_pkg::DELAY_W-1:0] per_in, per_out;
    logic [mcrt_pkg::COUNT_W-1:0] rem_in, rem_out;
    logic                         run_in, run_out, loop_in, loop_out;
    logic [TIME_BITS-1:0]         wait_post;
    logic                         no_fire;

    //--------------------------------------------------------------------
    // Control FSM
    //--------------------------------------------------------------------
    assign scan_done = (proc_idx_reg == CH_BITS'(NUM_CHANNELS - 1));
    assign send_done = out_ready && last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcrt_pkg::ST_IDLE:  if (in_valid) state_next = mcrt_pkg::ST_SCAN;
            mcrt_pkg::ST_SCAN:  if (scan_done) state_next = mcrt_pkg::ST_FETCH;
            mcrt_pkg::ST_FETCH: state_next = mcrt_pkg::ST_LOAD;
            mcrt_pkg::ST_LOAD:  state_next = mcrt_pkg::ST_OUT;
            mcrt_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = send_done ? mcrt_pkg::ST_IDLE : mcrt_pkg::ST_FETCH;
                end
            end
            default:            state_next = mcrt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        scan_active = 1'b0;
        load_active = 1'b0;
        unique case (state_reg)
            mcrt_pkg::ST_IDLE:  in_ready    = 1'b1;
            mcrt_pkg::ST_SCAN:  scan_active = 1'b1;
            mcrt_pkg::ST_LOAD:  load_active = 1'b1;
            mcrt_pkg::ST_FETCH,
            mcrt_pkg::ST_OUT:   in_ready    = 1'b0;
            default:            in_ready    = 1'b0;
        endcase
    end

    assign accept_in = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    //--------------------------------------------------------------------
    // Channel table: read entry i+1 while entry i is updated and written.
    // Entries never written read as their reset value.
    //--------------------------------------------------------------------
    assign ent_raddr = scan_active ? (proc_idx_reg + CH_BITS'(1)) : '0;
    assign ent_cur   = vld_reg[proc_idx_reg] ? ent_rdata : ENT_RESET;
    assign {dl_in, per_in, rem_in, run_in, loop_in} = ent_cur;

    mcrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_CHANNELS)
    ) u_table (
        .clk   (clk),
        .we    (scan_active),
        .waddr (proc_idx_reg),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    assign cmd = '{func: func_reg,
                   hit:  (CMP_W'(channel_reg) == CMP_W'(proc_idx_reg))};

    mcrt_chan_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .cmd           (cmd),
        .now           (now_reg),
        .dly           (delay_reg),
        .cnt           (count_reg),
        .deadline_in   (dl_in),
        .period_in     (per_in),
        .remaining_in  (rem_in),
        .running_in    (run_in),
        .looping_in    (loop_in),
        .deadline_out  (dl_out),
        .period_out    (per_out),
        .remaining_out (rem_out),
        .running_out   (run_out),
        .looping_out   (loop_out),
        .evt           (evt),
        .wait_post     (wait_post)
    );

    assign ent_wdata = {dl_out, per_out, rem_out, run_out, loop_out};

    //--------------------------------------------------------------------
    // Fired-channel queue, filled in scan order, drained by the send loop.
    //--------------------------------------------------------------------
    assign rq_we    = scan_active && evt.fire;
    assign rq_wdata = {proc_idx_reg, evt.fin};

    mcrt_ram #(
        .WIDTH (RQ_W),
        .DEPTH (NUM_CHANNELS)
    ) u_result_q (
        .clk   (clk),
        .we    (rq_we),
        .waddr (fire_cnt_reg[CH_BITS-1:0]),
        .wdata (rq_wdata),
        .raddr (rd_idx_reg[CH_BITS-1:0]),
        .rdata (rq_rdata)
    );

    //--------------------------------------------------------------------
    // Sequencing state
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            proc_idx_reg <= '0;
            fire_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            vld_reg      <= '0;
            any_reg      <= 1'b0;
            best_reg     <= '0;
        end
        else if (accept_in)
        begin
            // a tick bumps time before the sweep sees it
            if (mcrt_pkg::func_t'(func) == mcrt_pkg::FUNC_TICK)
            begin
                now_reg <= now_reg + TIME_BITS'(1);
            end
            proc_idx_reg <= '0;
            fire_cnt_reg <= '0;
            rd_idx_reg   <= '0;
            any_reg      <= 1'b0;
            best_reg     <= '0;
        end
        else if (scan_active)
        begin
            vld_reg[proc_idx_reg] <= 1'b1;
            if (evt.fire)
            begin
                fire_cnt_reg <= fire_cnt_reg + CNT_BITS'(1);
            end
            // running minimum of post-step waits
            if (run_out && (!any_reg || wait_post < best_reg))
            begin
                best_reg <= wait_post;
            end
            if (run_out)
            begin
                any_reg <= 1'b1;
            end
            if (!scan_done)
            begin
                proc_idx_reg <= proc_idx_reg + CH_BITS'(1);
            end
        end
        else if (state_reg == mcrt_pkg::ST_OUT && out_ready && !last_reg)
        begin
            rd_idx_reg <= rd_idx_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            func_reg    <= mcrt_pkg::func_t'(func);
            channel_reg <= channel;
            delay_reg   <= delay_ms;
            count_reg   <= repeat_count;
        end
    end

    //--------------------------------------------------------------------
    // Output register
    //--------------------------------------------------------------------
    assign no_fire = (fire_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_active)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_active)
        begin
            fired_reg         <= !no_fire;
            fired_channel_reg <= no_fire ? '0
                                 : mcrt_pkg::CHAN_W'(rq_rdata[RQ_W-1:1]);
            finished_reg      <= no_fire ? 1'b0 : rq_rdata[0];
            last_reg          <= no_fire || (rd_idx_reg + CNT_BITS'(1) == fire_cnt_reg);
            wait_out_reg      <= (EXT_W'(best_reg) > EXT_W'(mcrt_pkg::WAIT_MAX))
                                 ? mcrt_pkg::WAIT_MAX
                                 : mcrt_pkg::DELAY_W'(best_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign fired         = fired_reg;
    assign fired_channel = fired_channel_reg;
    assign finished      = finished_reg;
    assign last          = last_reg;
    assign any_running   = any_reg;
    assign next_wait_ms  = wait_out_reg;

    //--------------------------------------------------------------------
    // Checks
    //--------------------------------------------------------------------
    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "accept while busy")
    `ASSERT_ALWAYS(a_fire_bound, clk, rst_n, fire_cnt_reg <= CNT_BITS'(NUM_CHANNELS), "fire cnt")
    `ASSERT_IMPLIES(a_quiet_last, clk, rst_n, out_valid && !fired, last, "quiet not last")
    `ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_ready && last, in_ready, "not idle")

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused func codes: the unit must treat them as no-ops.
    localparam logic [2:0] FUNC_NOP_FIRST = 3'd5;
    localparam logic [2:0] FUNC_NOP_MID   = 3'd6;
    localparam logic [2:0] FUNC_NOP_LAST  = 3'd7;

    localparam int NCH        = 16;
    localparam int RAND_ITEMS = 176;
    localparam int CALM_AFTER = 140;   // no idling on either side past this count
    localparam int MAX_REPORT = 10;

    // One output transaction, in port order.
    typedef struct packed {
        logic                          fired;
        logic [mcrt_pkg::CHAN_W-1:0]   chan;
        logic                          fin;
        logic                          last;
        logic                          any_on;
        logic [mcrt_pkg::DELAY_W-1:0]  wait_ms;
    } tmr_result_t;

    // Directed row: command fields plus an optional hand-typed result.
    typedef struct packed {
        logic [2:0]                    f;
        logic [mcrt_pkg::CHAN_W-1:0]   ch;
        logic [mcrt_pkg::DELAY_W-1:0]  dly;
        logic [mcrt_pkg::COUNT_W-1:0]  cnt;
        logic                          typed;
        tmr_result_t                   res;
    } cmd_row_t;

    // Nothing running, no expiry: the only result a command or idle tick gives.
    localparam tmr_result_t QUIET = '{1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 31'd0};
    localparam tmr_result_t NONE  = '0;

    localparam int NROWS = 24;
    localparam cmd_row_t DIR_TAB [NROWS] = '{
        // fresh from reset: a tick with no channel running
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b1, QUIET},
        // unused codes with every payload bit set, then cleared
        '{FUNC_NOP_FIRST,           4'd15, 31'h7FFF_FFFF,  16'hFFFF,   1'b1, QUIET},
        '{FUNC_NOP_LAST,            4'd0,  31'd0,          16'd0,      1'b1, QUIET},
        '{mcrt_pkg::FUNC_STOP,      4'd0,  31'd0,          16'd0,      1'b1, QUIET},
        // longest period: the wait reads back at its maximum
        '{mcrt_pkg::FUNC_START,     4'd0,  31'h7FFF_FFFF,  16'd0,      1'b1,
          '{1'b0, 4'd0, 1'b0, 1'b1, 1'b1, mcrt_pkg::WAIT_MAX}},
        // zero period with the largest count: due at once
        '{mcrt_pkg::FUNC_START,     4'd15, 31'd0,          16'hFFFF,   1'b1,
          '{1'b0, 4'd0, 1'b0, 1'b1, 1'b1, 31'd0}},
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b1,
          '{1'b1, 4'd15, 1'b0, 1'b1, 1'b1, 31'd0}},
        // re-time a running channel
        '{mcrt_pkg::FUNC_SET_DELAY, 4'd15, 31'd2,          16'd0,      1'b0, NONE},
        // single-shot channel, then resumed after it has finished
        '{mcrt_pkg::FUNC_START,     4'd3,  31'd1,          16'd1,      1'b0, NONE},
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_RESUME,    4'd3,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b0, NONE},
        // counted channel of two, plus a period stored while stopped
        '{mcrt_pkg::FUNC_START,     4'd7,  31'd1,          16'd2,      1'b0, NONE},
        '{mcrt_pkg::FUNC_SET_DELAY, 4'd9,  31'd3,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_RESUME,    4'd9,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_TICK,      4'd5,  31'h5555_5555,  16'hAAAA,   1'b0, NONE},
        '{mcrt_pkg::FUNC_TICK,      4'd10, 31'h2AAA_AAAA,  16'h5555,   1'b0, NONE},
        '{FUNC_NOP_MID,             4'd10, 31'd12345,      16'd77,     1'b0, NONE},
        '{mcrt_pkg::FUNC_STOP,      4'd15, 31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_STOP,      4'd0,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_STOP,      4'd7,  31'd0,          16'd0,      1'b0, NONE},
        '{mcrt_pkg::FUNC_STOP,      4'd9,  31'd0,          16'd0,      1'b0, NONE},
        // everything stopped again
        '{mcrt_pkg::FUNC_TICK,      4'd0,  31'd0,          16'd0,      1'b1, QUIET}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [2:0]                    func = mcrt_pkg::FUNC_TICK;
    logic [mcrt_pkg::CHAN_W-1:0]   channel = '0;
    logic [mcrt_pkg::DELAY_W-1:0]  delay_ms = '0;
    logic [mcrt_pkg::COUNT_W-1:0]  repeat_count = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          fired;
    logic [mcrt_pkg::CHAN_W-1:0]   fired_channel;
    logic                          finished;
    logic                          last;
    logic                          any_running;
    logic [mcrt_pkg::DELAY_W-1:0]  next_wait_ms;

    multi_channel_repeat_timer_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .channel      (channel),
        .delay_ms     (delay_ms),
        .repeat_count (repeat_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fired        (fired),
        .fired_channel(fired_channel),
        .finished     (finished),
        .last         (last),
        .any_running  (any_running),
        .next_wait_ms (next_wait_ms)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer table predictor: own copy of the channel state.
    // ------------------------------------------------------------------
    logic [31:0]                   now_ms;
    logic [31:0]                   due_at    [NCH];
    logic [mcrt_pkg::DELAY_W-1:0]  per_ms    [NCH];
    logic [mcrt_pkg::COUNT_W-1:0]  left_cnt  [NCH];
    bit                            run_on    [NCH];
    bit                            forever_on[NCH];

    tmr_result_t         pending_results[$];   // expected output transactions, oldest first
    int                  mismatches = 0;
    int                  n_items = 0;
    int                  idle_pct = 0;         // chance of an input gap before a transaction
    int                  stall_pct = 0;        // chance per cycle of an output stall burst

    function automatic void timers_clear();
        now_ms = '0;
        for (int c = 0; c < NCH; c++)
        begin
            due_at[c]     = '0;
            per_ms[c]     = '0;
            left_cnt[c]   = '0;
            run_on[c]     = 1'b0;
            forever_on[c] = 1'b1;
        end
    endfunction

    // Deadline from now; periods of half the time range or more are clipped.
    function automatic void arm_channel(input int c);
        logic [31:0] p;
        p = {1'b0, per_ms[c]};
        if (p >= 32'h8000_0000)
            p = 32'h7FFF_FFFF;
        due_at[c] = now_ms + p;
    endfunction

    // Wrapping distance to the deadline; anything "behind" now counts as due.
    function automatic logic [31:0] time_left(input int c);
        logic [31:0] d;
        d = due_at[c] - now_ms;
        return d[31] ? 32'd0 : d;
    endfunction

    // Apply one command or tick, queue the results it causes.
    function automatic void timers_step(input logic [2:0] f,
                                        input logic [mcrt_pkg::CHAN_W-1:0] ch,
                                        input logic [mcrt_pkg::DELAY_W-1:0] dly,
                                        input logic [mcrt_pkg::COUNT_W-1:0] cnt);
        tmr_result_t  step_res[$];
        tmr_result_t  r;
        logic         fin;
        logic         any_on;
        logic [31:0]  best;
        logic [31:0]  w;
        any_on = 1'b0;
        best   = '0;
        if (f == mcrt_pkg::FUNC_TICK)
        begin
            now_ms = now_ms + 32'd1;
            for (int c = 0; c < NCH; c++)
            begin
                if (!run_on[c] || time_left(c) != 0)
                    continue;
                fin = 1'b0;
                if (!forever_on[c])
                begin
                    // a finished channel that was resumed fires once more and stops
                    if (left_cnt[c] <= 1)
                    begin
                        left_cnt[c] = '0;
                        run_on[c]   = 1'b0;
                        fin         = 1'b1;
                    end
                    else
                        left_cnt[c] = left_cnt[c] - mcrt_pkg::COUNT_W'(1);
                end
                if (run_on[c])
                    arm_channel(c);
                r = '{1'b1, mcrt_pkg::CHAN_W'(c), fin, 1'b0, 1'b0, 31'd0};
                step_res = {step_res, r};
            end
        end
        else
        begin
            case (f)
                mcrt_pkg::FUNC_START:
                begin
                    per_ms[ch]     = dly;
                    left_cnt[ch]   = cnt;
                    forever_on[ch] = (cnt == 0);
                    run_on[ch]     = 1'b1;
                    arm_channel(ch);
                end
                mcrt_pkg::FUNC_RESUME:
                begin
                    run_on[ch] = 1'b1;
                    arm_channel(ch);
                end
                mcrt_pkg::FUNC_SET_DELAY:
                begin
                    per_ms[ch] = dly;
                    if (run_on[ch])
                        arm_channel(ch);
                end
                mcrt_pkg::FUNC_STOP:
                    run_on[ch] = 1'b0;
                default: ;
            endcase
        end
        if (step_res.size() == 0)
        begin
            r = '0;
            step_res = {step_res, r};
        end

        for (int c = 0; c < NCH; c++)
        begin
            if (run_on[c])
            begin
                w = time_left(c);
                if (!any_on || w < best)
                    best = w;
                any_on = 1'b1;
            end
        end
        if (best > {1'b0, mcrt_pkg::WAIT_MAX})
            best = {1'b0, mcrt_pkg::WAIT_MAX};

        // status fields reflect the table after the whole step
        for (int k = 0; k < step_res.size(); k++)
        begin
            r         = step_res[k];
            r.last    = (k == step_res.size() - 1);
            r.any_on  = any_on;
            r.wait_ms = best[mcrt_pkg::DELAY_W-1:0];
            pending_results = {pending_results, r};
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive at the falling edge, accept at the rising edge.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [2:0] f, input logic [mcrt_pkg::CHAN_W-1:0] ch,
                            input logic [mcrt_pkg::DELAY_W-1:0] dly,
                            input logic [mcrt_pkg::COUNT_W-1:0] cnt,
                            input logic typed, input tmr_result_t res);
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        channel      <= ch;
        delay_ms     <= dly;
        repeat_count <= cnt;
        do
            @(posedge clk);
        while (!in_ready);
        timers_step(f, ch, dly, cnt);
        // hand-typed rows give exactly one result; it replaces the predicted one
        if (typed)
        begin
            void'(pending_results.pop_back());
            pending_results = {pending_results, res};
        end
        n_items++;
    endtask

    // Mostly short periods so channels keep firing; now and then a huge one.
    function automatic logic [mcrt_pkg::DELAY_W-1:0] pick_delay();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return mcrt_pkg::DELAY_W'($urandom_range(0, 6));
        else if (sel < 90)
            return mcrt_pkg::DELAY_W'($urandom);
        else
            return mcrt_pkg::WAIT_MAX - mcrt_pkg::DELAY_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [mcrt_pkg::COUNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return '0;
        else if (sel < 85)
            return mcrt_pkg::COUNT_W'($urandom_range(1, 3));
        else
            return mcrt_pkg::COUNT_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall bursts on out_ready.
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Scoreboard: every result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        tmr_result_t got;
        tmr_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{fired, fired_channel, finished, last, any_running, next_wait_ms};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("%0t: unexpected result fired=%0d ch=%0d fin=%0d last=%0d",
                             $realtime, got.fired, got.chan, got.fin, got.last);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.fired !== exp_r.fired || got.chan !== exp_r.chan ||
                    got.fin !== exp_r.fin || got.last !== exp_r.last ||
                    got.any_on !== exp_r.any_on || got.wait_ms !== exp_r.wait_ms)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                    begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  exp fired=%0d ch=%0d fin=%0d last=%0d any=%0d wait=%0d",
                                 exp_r.fired, exp_r.chan, exp_r.fin, exp_r.last,
                                 exp_r.any_on, exp_r.wait_ms);
                        $display("  got fired=%0d ch=%0d fin=%0d last=%0d any=%0d wait=%0d",
                                 got.fired, got.chan, got.fin, got.last,
                                 got.any_on, got.wait_ms);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random traffic.
    // ------------------------------------------------------------------
    initial
    begin
        cmd_row_t     row;
        int           sel;
        logic [2:0]   f;
        int           base;
        timers_clear();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs without idling
        for (int i = 0; i < NROWS; i++)
        begin
            row = DIR_TAB[i];
            send_cmd(row.f, row.ch, row.dly, row.cnt, row.typed, row.res);
        end

        base = n_items;
        while (n_items - base < RAND_ITEMS)
        begin
            // new idling mix every 25 transactions; none near the end
            if ((n_items - base) % 25 == 0)
            begin
                idle_pct  = 25 * $urandom_range(0, 2);
                stall_pct = 5 * $urandom_range(0, 2);
            end
            if (n_items - base >= CALM_AFTER)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end

            sel = $urandom_range(0, 99);
            if (sel < 45)
                // payload on a tick is don't-care; keep it noisy
                send_cmd(mcrt_pkg::FUNC_TICK, mcrt_pkg::CHAN_W'($urandom),
                         mcrt_pkg::DELAY_W'($urandom), mcrt_pkg::COUNT_W'($urandom),
                         1'b0, NONE);
            else if (sel < 64)
                send_cmd(mcrt_pkg::FUNC_START, mcrt_pkg::CHAN_W'($urandom), pick_delay(),
                         pick_count(), 1'b0, NONE);
            else if (sel < 72)
                send_cmd(mcrt_pkg::FUNC_RESUME, mcrt_pkg::CHAN_W'($urandom),
                         mcrt_pkg::DELAY_W'($urandom), mcrt_pkg::COUNT_W'($urandom),
                         1'b0, NONE);
            else if (sel < 81)
                send_cmd(mcrt_pkg::FUNC_SET_DELAY, mcrt_pkg::CHAN_W'($urandom),
                         pick_delay(), mcrt_pkg::COUNT_W'($urandom), 1'b0, NONE);
            else if (sel < 91)
                send_cmd(mcrt_pkg::FUNC_STOP, mcrt_pkg::CHAN_W'($urandom),
                         mcrt_pkg::DELAY_W'($urandom), mcrt_pkg::COUNT_W'($urandom),
                         1'b0, NONE);
            else if (sel < 97)
            begin
                f = 3'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
                send_cmd(f, mcrt_pkg::CHAN_W'($urandom), mcrt_pkg::DELAY_W'($urandom),
                         mcrt_pkg::COUNT_W'($urandom), 1'b0, NONE);
            end
            else
            begin
                // arm every channel one tick out, so the next tick fires all of them
                for (int c = 0; c < NCH; c++)
                    send_cmd(mcrt_pkg::FUNC_START, mcrt_pkg::CHAN_W'(c), 31'd1,
                             mcrt_pkg::COUNT_W'($urandom_range(0, 2)), 1'b0, NONE);
                send_cmd(mcrt_pkg::FUNC_TICK, '0, '0, '0, 1'b0, NONE);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then give the unit time to show any stray result
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mcrt_pkg.sv
hw/rtl/mcrt_ram.sv
hw/rtl/mcrt_chan_alu.sv
hw/rtl/multi_channel_repeat_timer_unit.sv
tb/tb.sv
